FILE: rtl/i2cmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cmts_pkg;

  localparam int PTR_W = 8;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_START = 3'd1,
    OP_BUS   = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE           = 4'd0,
    PH_START          = 4'd1,
    PH_TRANS          = 4'd2,
    PH_ADDR_RX        = 4'd3,
    PH_REC            = 4'd4,
    PH_ACK            = 4'd5,
    PH_STOP           = 4'd6,
    PH_STOPPING_FAULT = 4'd7,
    PH_FAULT          = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_WAS_IDLE   = 3'd1,
    ERR_NACK       = 3'd2,
    ERR_WRITE_FAIL = 3'd3,
    ERR_NOT_IDLE   = 3'd4
  } err_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] index;
    logic [7:0] data;
    logic [7:0] length;
    logic       ack_seen;
    logic [7:0] rx_byte;
    logic       bus_idle;
    logic       tx_full;
  } req_t;

  typedef struct packed {
    phase_t           phase;
    logic [PTR_W-1:0] ptr;
    logic [PTR_W-1:0] len;
  } seq_state_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  typedef struct packed {
    logic       write_strobe;
    logic [7:0] write_data;
    logic       start_strobe;
    logic       stop_strobe;
    logic       rx_enable;
    logic       ack_enable;
    logic       ack_value;
    err_t       error_code;
    phase_t     phase_now;
    logic [7:0] read_data;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/i2cmts_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cmts_buf
  import i2cmts_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic             clk,
  input  wire buf_wr_t          wr,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] data_q;
  logic       hit_q;
  logic       wr_ok;
  logic       rd_ok;

  assign wr_ok = wr.en && (wr.addr < PTR_W'(DEPTH));
  assign rd_ok = rd_addr < PTR_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // write in the same cycle as the read wins
  always_ff @(posedge clk) begin
    if (rd_en) begin
      hit_q <= rd_ok;
      if (wr_ok && (wr.addr == rd_addr)) begin
        data_q <= wr.data;
      end else begin
        data_q <= mem[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = hit_q ? data_q : 8'h00;

endmodule
`default_nettype wire

FILE: rtl/i2cmts_step.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cmts_step
  import i2cmts_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire req_t       req,
  input  wire seq_state_t st,
  input  wire logic [7:0] rd_data,
  output seq_state_t      st_next,
  output buf_wr_t         wr,
  output res_t            res
);

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(DEPTH);

  err_t             err;
  logic [PTR_W-1:0] ptr_adv;
  logic             done;
  logic             addr_read;

  assign ptr_adv   = (st.ptr < DEPTH_P) ? st.ptr + PTR_W'(1) : st.ptr;
  assign done      = st.ptr >= st.len;
  assign addr_read = rd_data[0];

  always_comb begin
    err = ERR_NONE;
    if (req.operation == OP_BUS) begin
      unique case (st.phase)
        PH_IDLE:    err = ERR_WAS_IDLE;
        PH_START:   if (req.tx_full) err = ERR_WRITE_FAIL;
        PH_TRANS: begin
          priority if (!req.ack_seen) err = ERR_NACK;
          else if (done) err = ERR_NONE;
          else if (!req.bus_idle) err = ERR_NOT_IDLE;
          else err = ERR_NONE;
        end
        PH_ADDR_RX: if (!req.ack_seen) err = ERR_NACK;
        default:    err = ERR_NONE;
      endcase
    end
  end

  // next state and buffer write
  always_comb begin
    st_next = st;
    wr      = '0;
    unique case (req.operation)
      OP_LOAD: begin
        wr.en   = 1'b1;
        wr.addr = {1'b0, req.index};
        wr.data = req.data;
      end
      OP_START: begin
        if (st.phase == PH_IDLE) begin
          st_next.len   = ({1'b0, req.length} > {1'b0, DEPTH_P}) ? DEPTH_P : req.length;
          st_next.phase = PH_START;
        end
      end
      OP_BUS: begin
        unique case (st.phase)
          PH_START: begin
            st_next.ptr   = addr_read ? '0 : PTR_W'(1);
            st_next.phase = addr_read ? PH_ADDR_RX : PH_TRANS;
          end
          PH_TRANS: begin
            if (req.ack_seen && done) begin
              st_next.phase = PH_STOP;
            end else if (req.ack_seen && req.bus_idle) begin
              st_next.ptr = ptr_adv;
            end
          end
          PH_ADDR_RX: if (req.ack_seen) st_next.phase = PH_REC;
          PH_REC: begin
            wr.en         = 1'b1;
            wr.addr       = st.ptr;
            wr.data       = req.rx_byte;
            st_next.ptr   = ptr_adv;
            st_next.phase = PH_ACK;
          end
          PH_ACK:            st_next.phase = done ? PH_STOP : PH_REC;
          PH_STOP:           st_next.phase = PH_IDLE;
          PH_STOPPING_FAULT: st_next.phase = PH_FAULT;
          default:           st_next.phase = st.phase;
        endcase
        if (err != ERR_NONE) st_next.phase = PH_STOPPING_FAULT;
      end
      OP_CLEAR: if (st.phase == PH_FAULT) st_next.phase = PH_IDLE;
      default: st_next = st;
    endcase
  end

  always_comb begin
    res            = '0;
    res.error_code = err;
    res.phase_now  = st_next.phase;
    unique case (req.operation)
      OP_START: res.start_strobe = (st.phase == PH_IDLE);
      OP_READ:  res.read_data = rd_data;
      OP_BUS: begin
        unique case (st.phase)
          PH_START: begin
            res.write_strobe = !req.tx_full;
            res.write_data   = req.tx_full ? 8'h00 : rd_data;
          end
          PH_TRANS: begin
            if (req.ack_seen && done) begin
              res.stop_strobe = 1'b1;
            end else if (req.ack_seen && req.bus_idle && !req.tx_full) begin
              res.write_strobe = 1'b1;
              res.write_data   = rd_data;
            end
          end
          PH_ADDR_RX: res.rx_enable = req.ack_seen;
          PH_REC: begin
            res.ack_enable = 1'b1;
            res.ack_value  = ptr_adv >= st.len;
          end
          PH_ACK: begin
            res.stop_strobe = done;
            res.rx_enable   = !done;
          end
          default: res.rx_enable = 1'b0;
        endcase
        if (err != ERR_NONE) res.stop_strobe = 1'b1;
      end
      default: res.read_data = 8'h00;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/i2c_master_transaction_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// I2C master transaction sequencer. Each request (buffer load, start, bus event,
// buffer read, fault clear) yields exactly one result carrying the bus strobes,
// an error code and the phase after the request. One request is taken per clock;
// a request is loaded into the input register as the transfer buffer is read, and
// its result is loaded into the result register when it leaves the input register.
// A result held by res_ready low keeps the request behind it in the input register
// and drops req_ready.
// The buffer has one write and one read port; its contents are undefined until
// written. BUF_DEPTH sets the buffer size and the saturation limit of the length
// and byte pointer.
module i2c_master_transaction_sequencer_core
  import i2cmts_pkg::*;
#(
  parameter int BUF_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic [2:0] operation,
  input  wire logic [6:0] index,
  input  wire logic [7:0] data,
  input  wire logic [7:0] length,
  input  wire logic       ack_seen,
  input  wire logic [7:0] rx_byte,
  input  wire logic       bus_idle,
  input  wire logic       tx_full,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic            write_strobe,
  output logic [7:0]      write_data,
  output logic            start_strobe,
  output logic            stop_strobe,
  output logic            rx_enable,
  output logic            ack_enable,
  output logic            ack_value,
  output logic [2:0]      error_code,
  output logic [3:0]      phase_now,
  output logic [7:0]      read_data
);

  req_t             req;
  logic             req_full;
  seq_state_t       st;
  seq_state_t       st_next;
  seq_state_t       st_eff;
  buf_wr_t          step_wr;
  buf_wr_t          buf_wr;
  res_t             step_res;
  res_t             res;
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic             advance;
  logic             fire;
  logic             accept;

  assign advance   = !res_valid || res_ready;
  assign fire      = req_full && advance;
  assign req_ready = !req_full || advance;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (accept) begin
      req_full <= 1'b1;
    end else if (fire) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= '{operation, index, data, length, ack_seen, rx_byte, bus_idle, tx_full};
    end
  end

  // state as the incoming request will see it
  assign st_eff = fire ? st_next : st;

  always_comb begin
    priority if (operation == OP_READ) rd_addr = {1'b0, index};
    else if (st_eff.phase == PH_START) rd_addr = '0;
    else rd_addr = st_eff.ptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{PH_IDLE, '0, '0};
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_comb begin
    buf_wr    = step_wr;
    buf_wr.en = step_wr.en && fire;
  end

  i2cmts_buf #(
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr     (buf_wr),
    .rd_en  (accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  i2cmts_step #(
    .DEPTH(BUF_DEPTH)
  ) u_step (
    .req    (req),
    .st     (st),
    .rd_data(rd_data),
    .st_next(st_next),
    .wr     (step_wr),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_res;
    end
  end

  assign write_strobe = res.write_strobe;
  assign write_data   = res.write_data;
  assign start_strobe = res.start_strobe;
  assign stop_strobe  = res.stop_strobe;
  assign rx_enable    = res.rx_enable;
  assign ack_enable   = res.ack_enable;
  assign ack_value    = res.ack_value;
  assign error_code   = res.error_code;
  assign phase_now    = res.phase_now;
  assign read_data    = res.read_data;

endmodule
`default_nettype wire

FILE: rtl/i2cmts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       write_strobe,
  input wire logic [7:0] write_data,
  input wire logic       start_strobe,
  input wire logic       stop_strobe,
  input wire logic       ack_enable,
  input wire logic       ack_value,
  input wire logic [2:0] error_code,
  input wire logic [3:0] phase_now
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(phase_now) && $stable(write_data))
    else $error("stalled result changed");

  a_wdata_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !write_strobe |-> write_data == 8'h00)
    else $error("write data without write strobe");

  a_ack_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !ack_enable |-> !ack_value)
    else $error("ack value without ack enable");

  a_err_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> stop_strobe && phase_now == PH_STOPPING_FAULT)
    else $error("error without stop and fault phase");

  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid && start_strobe |-> phase_now == PH_START && !stop_strobe)
    else $error("start strobe outside start phase");

endmodule

bind i2c_master_transaction_sequencer_core i2cmts_checker u_i2cmts_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .write_strobe(write_strobe),
  .write_data  (write_data),
  .start_strobe(start_strobe),
  .stop_strobe (stop_strobe),
  .ack_enable  (ack_enable),
  .ack_value   (ack_value),
  .error_code  (error_code),
  .phase_now   (phase_now)
);
`default_nettype wire
